### sv/hbff_pkg.sv
// ----------------------------------------------------------------------------
// hbff_pkg
// Shared types, constants and tree address helpers for the bitmap block.
// ----------------------------------------------------------------------------
package hbff_pkg;

    localparam int WORD_W     = 32;
    localparam int IDX_W      = 15;
    localparam int POS_W      = 5;
    localparam int LEVELS_DEF = 2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD,
        ST_UPD,
        ST_ROOT,
        ST_FIND
    } hbff_state_t;

    typedef struct packed {
        logic clr_en;
        logic load;
        logic rd_leaf;
        logic upd;
        logic upd_wr;
        logic up_rd;
        logic root_rd;
        logic find_step;
        logic out_load;
    } hbff_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic lvl_top;
        logic lvl_leaf;
        logic func;
        logic out_busy;
    } hbff_sts_t;

    // first word of a tree level: 0, 1, 33, 1057
    function automatic logic [31:0] tree_base(input logic [1:0] lvl);
        logic [31:0] b;
        b = '0;
        for (int j = 0; j < 3; j++)
        begin
            if (2'(j) < lvl)
            begin
                b = (b << 5) + 32'd1;
            end
        end
        return b;
    endfunction

    function automatic logic [4:0] level_shift(input logic [1:0] lvl, input logic [1:0] levels);
        logic [4:0] d;
        d = 5'(levels - lvl);
        return 5'(d * 5'd5);
    endfunction

    function automatic logic [31:0] node_addr(input logic [1:0] lvl,
                                              input logic [IDX_W-1:0] idx,
                                              input logic [1:0] levels);
        logic [4:0] sh;
        sh = level_shift(lvl, levels);
        return tree_base(lvl) + 32'(idx >> (sh + 5'd5));
    endfunction

    function automatic logic [POS_W-1:0] node_bit(input logic [1:0] lvl,
                                                  input logic [IDX_W-1:0] idx,
                                                  input logic [1:0] levels);
        logic [4:0] sh;
        sh = level_shift(lvl, levels);
        return POS_W'(idx >> sh);
    endfunction

    // leading zeros, msb first; an empty word gives 31
    function automatic logic [POS_W-1:0] lead_zeros(input logic [WORD_W-1:0] w);
        logic [POS_W-1:0] z;
        z = POS_W'(WORD_W - 1);
        for (int i = 0; i < WORD_W; i++)
        begin
            if (w[i])
            begin
                z = POS_W'(WORD_W - 1 - i);
            end
        end
        return z;
    endfunction

endpackage

### sv/hierarchical_bitmap_find_first.sv
// ----------------------------------------------------------------------------
// hierarchical_bitmap_find_first
// Bit array held as the leaves of a 32-ary summary tree with find-first-set.
// ----------------------------------------------------------------------------
// Request beat: func (0 read, 1 write), bit_index, write_value on
// req_valid/req_stall. Response beat: read_bit (value before the write),
// any_set and first_set_index (lowest set position, 0 when empty) on
// rsp_valid/rsp_stall. One response per request, in order.
// One item is in work at a time; the tree memory has one read and one write
// port with registered read data, and each tree level costs one access.
// Each item runs leaf read, leaf check, root read and LEVELS+1 descent
// steps, the last of which loads the result into the output register; a
// write turns the leaf check into a read-modify-write walk up to the root.
// The next request is taken only after the result has been loaded.
// After reset the block clears the whole tree of 32**LEVELS +
// (32**LEVELS-1)/31 words (1057 at LEVELS = 2), one word a cycle;
// req_stall is high until then.
// A response waits in the output register while rsp_stall is high; the next
// request is still taken and worked, and only its final load waits.
// ----------------------------------------------------------------------------
module hierarchical_bitmap_find_first
    import hbff_pkg::*;
#(
    parameter int LEVELS = LEVELS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  logic             func,
    input  logic [IDX_W-1:0] bit_index,
    input  logic             write_value,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output logic             read_bit,
    output logic             any_set,
    output logic [IDX_W-1:0] first_set_index
);

    hbff_cmd_t cmd;
    hbff_sts_t sts;

    hbff_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    hbff_dp #(
        .LEVELS (LEVELS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .func            (func),
        .bit_index       (bit_index),
        .write_value     (write_value),
        .rsp_stall       (rsp_stall),
        .rsp_valid       (rsp_valid),
        .read_bit        (read_bit),
        .any_set         (any_set),
        .first_set_index (first_set_index)
    );

endmodule

### sv/hbff_ctrl.sv
// ----------------------------------------------------------------------------
// hbff_ctrl
// Sequencer: clearing pass, leaf read-modify-write, walk up, walk down.
// ----------------------------------------------------------------------------
module hbff_ctrl
    import hbff_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  hbff_sts_t sts,
    output hbff_cmd_t cmd
);

    hbff_state_t state_reg;
    hbff_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (!sts.func || sts.lvl_top)
                begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                state_next = ST_FIND;
            end
            ST_FIND:
            begin
                if (sts.lvl_leaf && !sts.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_stall = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_en = 1'b1;
            end
            ST_IDLE:
            begin
                req_stall = 1'b0;
                cmd.load  = req_valid;
            end
            ST_RD:
            begin
                cmd.rd_leaf = 1'b1;
            end
            ST_UPD:
            begin
                cmd.upd    = 1'b1;
                cmd.upd_wr = sts.func;
                cmd.up_rd  = sts.func && !sts.lvl_top;
            end
            ST_ROOT:
            begin
                cmd.root_rd = 1'b1;
            end
            ST_FIND:
            begin
                cmd.find_step = !sts.lvl_leaf;
                cmd.out_load  = sts.lvl_leaf && !sts.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !(cmd.upd_wr || cmd.clr_en))
        else $error("memory write while idle");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !sts.out_busy)
        else $error("result loaded over a stalled beat");

    a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> req_stall)
        else $error("input taken during clearing pass");

    a_read_no_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPD && !sts.func) |=> (state_reg == ST_ROOT))
        else $error("read item walked the tree");

endmodule

### sv/hbff_dp.sv
// ----------------------------------------------------------------------------
// hbff_dp
// Datapath: tree word memory, level/address logic, result registers.
// ----------------------------------------------------------------------------
module hbff_dp
    import hbff_pkg::*;
#(
    parameter int LEVELS = LEVELS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  hbff_cmd_t        cmd,
    output hbff_sts_t        sts,
    input  logic             func,
    input  logic [IDX_W-1:0] bit_index,
    input  logic             write_value,
    input  logic             rsp_stall,
    output logic             rsp_valid,
    output logic             read_bit,
    output logic             any_set,
    output logic [IDX_W-1:0] first_set_index
);

    localparam int LEAF_WORDS  = 1 << (5 * LEVELS);
    localparam int INNER_WORDS = (LEAF_WORDS - 1) / 31;
    localparam int TREE_WORDS  = INNER_WORDS + LEAF_WORDS;
    localparam int AW          = $clog2(TREE_WORDS);
    localparam int LVL_W       = $clog2(LEVELS + 1);
    localparam int CAP_BITS    = 5 * (LEVELS + 1);
    localparam logic [IDX_W-1:0] CAP_MASK = (CAP_BITS >= IDX_W) ? {IDX_W{1'b1}}
                                          : IDX_W'((1 << CAP_BITS) - 1);

    logic [WORD_W-1:0] mem [TREE_WORDS];
    logic [WORD_W-1:0] rdata_reg;

    logic [AW-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [LVL_W-1:0] lvl_reg, lvl_next;
    logic             out_valid_reg, out_valid_next;

    logic [IDX_W-1:0] idx_reg;
    logic             func_reg;
    logic             val_reg;
    logic             child_nz_reg;
    logic             rd_bit_reg;
    logic             any_reg;
    logic [IDX_W-1:0] pos_reg;
    logic             read_bit_reg;
    logic             any_set_reg;
    logic [IDX_W-1:0] first_reg;

    logic [1:0]        lvl2;
    logic [AW-1:0]     cur_addr, par_addr, find_addr;
    logic [POS_W-1:0]  cur_bit, zcnt;
    logic [WORD_W-1:0] bit_mask, new_word, wdata;
    logic              set_val;
    logic [IDX_W-1:0]  pos_step;
    logic              mem_we, mem_re;
    logic [AW-1:0]     waddr, raddr;

    always_comb
    begin
        lvl2      = 2'(lvl_reg);
        cur_addr  = AW'(node_addr(lvl2, idx_reg, 2'(LEVELS)));
        par_addr  = AW'(node_addr(lvl2 - 2'd1, idx_reg, 2'(LEVELS)));
        cur_bit   = node_bit(lvl2, idx_reg, 2'(LEVELS));
        bit_mask  = {1'b1, {(WORD_W-1){1'b0}}} >> cur_bit;
        set_val   = sts.lvl_leaf ? val_reg : child_nz_reg;
        new_word  = set_val ? (rdata_reg | bit_mask) : (rdata_reg & ~bit_mask);
        zcnt      = lead_zeros(rdata_reg);
        pos_step  = {pos_reg[IDX_W-POS_W-1:0], zcnt};
        find_addr = AW'(tree_base(lvl2 + 2'd1) + 32'(pos_step));
    end

    always_comb
    begin
        mem_we = cmd.clr_en || cmd.upd_wr;
        waddr  = cmd.clr_en ? clr_cnt_reg : cur_addr;
        wdata  = cmd.clr_en ? '0 : new_word;
        mem_re = cmd.rd_leaf || cmd.up_rd || cmd.root_rd || cmd.find_step;
        if (cmd.rd_leaf)
        begin
            raddr = cur_addr;
        end
        else if (cmd.up_rd)
        begin
            raddr = par_addr;
        end
        else if (cmd.find_step)
        begin
            raddr = find_addr;
        end
        else
        begin
            raddr = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_comb
    begin
        clr_cnt_next   = cmd.clr_en ? clr_cnt_reg + AW'(1) : clr_cnt_reg;
        lvl_next       = lvl_reg;
        if (cmd.load)
        begin
            lvl_next = LVL_W'(LEVELS);
        end
        else if (cmd.up_rd)
        begin
            lvl_next = lvl_reg - LVL_W'(1);
        end
        else if (cmd.root_rd)
        begin
            lvl_next = '0;
        end
        else if (cmd.find_step)
        begin
            lvl_next = lvl_reg + LVL_W'(1);
        end
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            lvl_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_cnt_reg   <= clr_cnt_next;
            lvl_reg       <= lvl_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            idx_reg  <= bit_index & CAP_MASK;
            func_reg <= func;
            val_reg  <= write_value;
        end
        if (cmd.upd)
        begin
            child_nz_reg <= |new_word;
            if (sts.lvl_leaf)
            begin
                rd_bit_reg <= |(rdata_reg & bit_mask);
            end
        end
        if (cmd.root_rd)
        begin
            pos_reg <= '0;
        end
        else if (cmd.find_step)
        begin
            pos_reg <= pos_step;
            if (sts.lvl_top)
            begin
                any_reg <= |rdata_reg;
            end
        end
        if (cmd.out_load)
        begin
            read_bit_reg <= rd_bit_reg;
            any_set_reg  <= any_reg;
            first_reg    <= any_reg ? pos_step : '0;
        end
    end

    always_comb
    begin
        sts.clr_done = (clr_cnt_reg == AW'(TREE_WORDS - 1));
        sts.lvl_top  = (lvl_reg == '0);
        sts.lvl_leaf = (lvl_reg == LVL_W'(LEVELS));
        sts.func     = func_reg;
        sts.out_busy = out_valid_reg && rsp_stall;
    end

    assign rsp_valid       = out_valid_reg;
    assign read_bit        = read_bit_reg;
    assign any_set         = any_set_reg;
    assign first_set_index = first_reg;

    a_lvl_range: assert property (@(posedge clk) disable iff (!rst_n)
        lvl_reg <= LVL_W'(LEVELS))
        else $error("tree level out of range");

    a_one_write_src: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.clr_en && cmd.upd_wr))
        else $error("clear and update write together");

endmodule
